### rtl/core/hatoaa_pkg.sv
// ----------------------------------------------------------------------------
// hatoaa_pkg
// Shared widths and elaboration-time CORDIC constants (arctangent steps, gain).
// ----------------------------------------------------------------------------
`default_nettype none

package hatoaa_pkg;

	localparam int TRIG_FRAC = 30;
	localparam int TW = 34;          // sin/cos datapath, Q30
	localparam int VW = 64;          // vector datapath, Q60

	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = {rem[63:0], n[k]};
			q = q << 1;
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] div_shl(input logic [63:0] n, input int s,
			input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] q;
		logic b;
		rem = '0;
		q = '0;
		for (int k = 0; k < 64 + s; k++) begin
			b = (k < 64) ? n[63 - k] : 1'b0;
			rem = {rem[63:0], b};
			q = q << 1;
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] b;
		v = v_in;
		res = '0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++)
			if (b > v) b = b >> 2;
		for (int k = 0; k < 32; k++) begin
			if (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	function automatic logic [63:0] atan_inv_q60(input logic [63:0] m);
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] t;
		p = udiv64(64'd1 << 60, m);
		sum = '0;
		for (int k = 0; k < 64; k++) begin
			if (p != 0) begin
				t = udiv64(p, 64'(2 * k + 1));
				if (k % 2 == 1) sum = sum - t;
				else sum = sum + t;
				p = udiv64(p, m * m);
			end
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_step(input int i, input int abits);
		logic [63:0] pi_q;
		logic [63:0] twopi;
		logic [63:0] at;
		logic [63:0] t;
		int sh;
		pi_q = 64'd16 * atan_inv_q60(64'd5) - 64'd4 * atan_inv_q60(64'd239);
		twopi = 64'd2 * pi_q;
		at = '0;
		if (i == 0) return 64'd1 << (abits - 3);
		for (int k = 0; k < 64; k++) begin
			sh = i * (2 * k + 1);
			if (sh <= 60) begin
				t = udiv64(64'd1 << (60 - sh), 64'(2 * k + 1));
				if (k % 2 == 1) at = at - t;
				else at = at + t;
			end
		end
		return (div_shl(at, abits + 1, twopi) + 64'd1) >> 1;
	endfunction

	function automatic logic [63:0] gain_q30(input int iters);
		logic [63:0] prod;
		prod = 64'd1 << 60;
		for (int i = 0; i < iters; i++)
			if (2 * i <= 62) prod = prod + (prod >> (2 * i));
		return isqrt64(div_shl(64'd1, 120, prod));
	endfunction

endpackage

`default_nettype wire

### rtl/core/hatoaa_rot_cell.sv
// ----------------------------------------------------------------------------
// hatoaa_rot_cell
// One rotation-mode CORDIC iteration on three angle lanes, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hatoaa_rot_cell
	import hatoaa_pkg::*;
#(
	parameter int A = 32,
	parameter int IDX = 0,
	parameter int SW = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                v_in,
	output logic                     rdy_out,
	input  wire logic signed [TW-1:0] x_in [3],
	input  wire logic signed [TW-1:0] y_in [3],
	input  wire logic signed [A-1:0]  a_in [3],
	input  wire logic [SW-1:0]        side_in,
	output logic                     v_out,
	input  wire logic                rdy_in,
	output logic signed [TW-1:0]     x_out [3],
	output logic signed [TW-1:0]     y_out [3],
	output logic signed [A-1:0]      a_out [3],
	output logic [SW-1:0]            side_out
);

	localparam logic signed [A-1:0] STEP = A'(atan_step(IDX, A));

	logic v_q;
	logic signed [TW-1:0] nx [3];
	logic signed [TW-1:0] ny [3];
	logic signed [A-1:0]  na [3];

	assign rdy_out = !v_q || rdy_in;
	assign v_out = v_q;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			if (a_in[l] >= 0) begin
				nx[l] = x_in[l] - (y_in[l] >>> IDX);
				ny[l] = y_in[l] + (x_in[l] >>> IDX);
				na[l] = a_in[l] - STEP;
			end else begin
				nx[l] = x_in[l] + (y_in[l] >>> IDX);
				ny[l] = y_in[l] - (x_in[l] >>> IDX);
				na[l] = a_in[l] + STEP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (rdy_out) v_q <= v_in;
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_in) begin
			x_out <= nx;
			y_out <= ny;
			a_out <= na;
			side_out <= side_in;
		end
	end

endmodule

`default_nettype wire

### rtl/core/hatoaa_vec_cell.sv
// ----------------------------------------------------------------------------
// hatoaa_vec_cell
// One vectoring-mode CORDIC iteration, registered, with a passed sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module hatoaa_vec_cell
	import hatoaa_pkg::*;
#(
	parameter int A = 32,
	parameter int IDX = 0,
	parameter int SW = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 v_in,
	output logic                      rdy_out,
	input  wire logic signed [VW-1:0] x_in,
	input  wire logic signed [VW-1:0] y_in,
	input  wire logic [A-1:0]         a_in,
	input  wire logic [SW-1:0]        side_in,
	output logic                      v_out,
	input  wire logic                 rdy_in,
	output logic signed [VW-1:0]      x_out,
	output logic signed [VW-1:0]      y_out,
	output logic [A-1:0]              a_out,
	output logic [SW-1:0]             side_out
);

	localparam logic [A-1:0] STEP = A'(atan_step(IDX, A));

	logic v_q;

	assign rdy_out = !v_q || rdy_in;
	assign v_out = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (rdy_out) v_q <= v_in;
	end

	always_ff @(posedge clk) begin
		if (rdy_out && v_in) begin
			if (y_in >= 0) begin
				x_out <= x_in + (y_in >>> IDX);
				y_out <= y_in - (x_in >>> IDX);
				a_out <= a_in + STEP;
			end else begin
				x_out <= x_in - (y_in >>> IDX);
				y_out <= y_in + (x_in >>> IDX);
				a_out <= a_in - STEP;
			end
			side_out <= side_in;
		end
	end

endmodule

`default_nettype wire

### rtl/core/hour_angle_to_alt_az_core.sv
// ----------------------------------------------------------------------------
// hour_angle_to_alt_az_core
// Hour angle / declination to azimuth / altitude at a programmable latitude.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle while the output does not stall
// (a rotation CORDIC chain for sin/cos, a multiply section, then two
// vectoring CORDIC chains for azimuth and altitude). Each stage advances
// whenever it is empty or its successor moves, so bubbles close up under
// output stalls. Write site_latitude only while no item is in flight.
`default_nettype none

module hour_angle_to_alt_az_core
	import hatoaa_pkg::*;
#(
	parameter int ANGLE_BITS = 32,
	parameter int CORDIC_ITERATIONS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // hour_angle[31:0], declination[63:32]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // azimuth[31:0], altitude[63:32]
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int A = ANGLE_BITS;
	localparam int N = CORDIC_ITERATIONS;
	localparam logic [2:0] ADDR_LAT = 3'd0;
	localparam logic signed [TW-1:0] K_Q30 = TW'(gain_q30(N));
	localparam logic signed [A-1:0] QTR = A'(1) << (A - 2);

	// configuration
	logic [31:0] lat_q;
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_LAT) ? lat_q : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lat_q <= 32'd0;
		else if (psel && penable && pwrite && paddr == ADDR_LAT) lat_q <= pwdata;
	end

	// port angle to internal angle, folded into +-quarter
	logic [31:0] port_ang [3];
	logic signed [A-1:0] ang_in [3];
	logic signed [A-1:0] ang_f [3];
	logic [2:0] neg_in;
	logic [A+31:0] ext [3];

	assign port_ang[0] = s_tdata[31:0];
	assign port_ang[1] = s_tdata[63:32];
	assign port_ang[2] = lat_q;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			ext[l] = {port_ang[l], A'(0)};
			ang_in[l] = ext[l][A+31:32];
			neg_in[l] = (ang_in[l] > QTR) || (ang_in[l] < -QTR);
			ang_f[l] = neg_in[l] ? {~ang_in[l][A-1], ang_in[l][A-2:0]} : ang_in[l];
		end
	end

	// rotation chain
	logic rv [N+1];
	logic rr [N+1];
	logic signed [TW-1:0] rx [N+1][3];
	logic signed [TW-1:0] ry [N+1][3];
	logic signed [A-1:0]  ra [N+1][3];
	logic [2:0] rs [N+1];

	assign rv[0] = s_tvalid;
	assign s_tready = rr[0];
	assign rs[0] = neg_in;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			rx[0][l] = K_Q30;
			ry[0][l] = '0;
			ra[0][l] = ang_f[l];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		hatoaa_rot_cell #(.A(A), .IDX(i), .SW(3)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.v_in(rv[i]), .rdy_out(rr[i]),
			.x_in(rx[i]), .y_in(ry[i]), .a_in(ra[i]), .side_in(rs[i]),
			.v_out(rv[i+1]), .rdy_in(rr[i+1]),
			.x_out(rx[i+1]), .y_out(ry[i+1]), .a_out(ra[i+1]), .side_out(rs[i+1])
		);
	end

	// multiply section
	logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy8;
	logic signed [TW-1:0] ch_s1, sh_s1, cd_s1, sd_s1, cl_s1, sl_s1;
	logic signed [VW-1:0] cdch_s2, cdsh_s2, sdcl_s2, sdsl_s2;
	logic signed [TW-1:0] cl_s2, sl_s2;
	logic signed [TW-1:0] cdch_s3, cl_s3, sl_s3;
	logic signed [VW-1:0] y_s3, sdcl_s3, sdsl_s3;
	logic signed [VW-1:0] y_s4, sdcl_s4, sdsl_s4, pxs_s4, pzc_s4;
	logic signed [VW-1:0] x_s5, y_s5, z_s5;
	logic signed [VW-1:0] x_s6, y_s6;
	logic [A-1:0] ang_s6;
	logic [VW:0] side_s6;
	logic signed [VW-1:0] r_s7, z_s7;
	logic [A-1:0] az_s7;
	logic signed [VW-1:0] x_s8, y_s8;
	logic [A-1:0] ang_s8;
	logic [A:0] side_s8;

	logic av [N+1];
	logic ar [N+1];
	logic signed [VW-1:0] ax [N+1];
	logic signed [VW-1:0] ay [N+1];
	logic [A-1:0] aa [N+1];
	logic [VW:0] as_ [N+1];

	logic bv [N+1];
	logic br [N+1];
	logic signed [VW-1:0] bx [N+1];
	logic signed [VW-1:0] by [N+1];
	logic [A-1:0] ba [N+1];
	logic [A:0] bs [N+1];

	logic rdy_o;

	assign rr[N] = rdy1;
	assign rdy1 = !v1_q || rdy2;
	assign rdy2 = !v2_q || rdy3;
	assign rdy3 = !v3_q || rdy4;
	assign rdy4 = !v4_q || rdy5;
	assign rdy5 = !v5_q || rdy6;
	assign rdy6 = !v6_q || ar[0];
	assign rdy7 = !v7_q || rdy8;
	assign rdy8 = !v8_q || br[0];
	assign rdy_o = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
			v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (rdy1) v1_q <= rv[N];
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
			if (rdy5) v5_q <= v4_q;
			if (rdy6) v6_q <= v5_q;
			if (rdy7) v7_q <= av[N];
			if (rdy8) v8_q <= v7_q;
			if (rdy_o) m_tvalid <= bv[N];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && rv[N]) begin
			ch_s1 <= rs[N][0] ? -rx[N][0] : rx[N][0];
			sh_s1 <= rs[N][0] ? -ry[N][0] : ry[N][0];
			cd_s1 <= rs[N][1] ? -rx[N][1] : rx[N][1];
			sd_s1 <= rs[N][1] ? -ry[N][1] : ry[N][1];
			cl_s1 <= rs[N][2] ? -rx[N][2] : rx[N][2];
			sl_s1 <= rs[N][2] ? -ry[N][2] : ry[N][2];
		end
		if (rdy2 && v1_q) begin
			cdch_s2 <= VW'(cd_s1) * VW'(ch_s1);
			cdsh_s2 <= VW'(cd_s1) * VW'(sh_s1);
			sdcl_s2 <= VW'(sd_s1) * VW'(cl_s1);
			sdsl_s2 <= VW'(sd_s1) * VW'(sl_s1);
			cl_s2 <= cl_s1;
			sl_s2 <= sl_s1;
		end
		if (rdy3 && v2_q) begin
			cdch_s3 <= TW'((cdch_s2 + (VW'(1) << (TRIG_FRAC - 1))) >>> TRIG_FRAC);
			y_s3 <= -cdsh_s2;
			sdcl_s3 <= sdcl_s2;
			sdsl_s3 <= sdsl_s2;
			cl_s3 <= cl_s2;
			sl_s3 <= sl_s2;
		end
		if (rdy4 && v3_q) begin
			pxs_s4 <= VW'(cdch_s3) * VW'(sl_s3);
			pzc_s4 <= VW'(cdch_s3) * VW'(cl_s3);
			y_s4 <= y_s3;
			sdcl_s4 <= sdcl_s3;
			sdsl_s4 <= sdsl_s3;
		end
		if (rdy5 && v4_q) begin
			x_s5 <= sdcl_s4 - pxs_s4;
			z_s5 <= sdsl_s4 + pzc_s4;
			y_s5 <= y_s4;
		end
		if (rdy6 && v5_q) begin
			side_s6 <= {z_s5, (x_s5 == 0) && (y_s5 == 0)};
			if (x_s5 < 0) begin
				if (y_s5 >= 0) begin
					x_s6 <= y_s5; y_s6 <= -x_s5; ang_s6 <= QTR;
				end else begin
					x_s6 <= -y_s5; y_s6 <= x_s5; ang_s6 <= -QTR;
				end
			end else begin
				x_s6 <= x_s5; y_s6 <= y_s5; ang_s6 <= '0;
			end
		end
		if (rdy7 && av[N]) begin
			r_s7 <= as_[N][0] ? VW'(0) :
				VW'(TW'(ax[N] >>> TRIG_FRAC)) * VW'(K_Q30);
			az_s7 <= as_[N][0] ? A'(0) : aa[N];
			z_s7 <= as_[N][VW:1];
		end
		if (rdy8 && v7_q) begin
			side_s8 <= {az_s7, (r_s7 == 0) && (z_s7 == 0)};
			if (r_s7 < 0) begin
				if (z_s7 >= 0) begin
					x_s8 <= z_s7; y_s8 <= -r_s7; ang_s8 <= QTR;
				end else begin
					x_s8 <= -z_s7; y_s8 <= r_s7; ang_s8 <= -QTR;
				end
			end else begin
				x_s8 <= r_s7; y_s8 <= z_s7; ang_s8 <= '0;
			end
		end
	end

	// azimuth chain
	assign av[0] = v6_q;
	assign ax[0] = x_s6;
	assign ay[0] = y_s6;
	assign aa[0] = ang_s6;
	assign as_[0] = side_s6;
	assign ar[N] = rdy7;

	for (genvar i = 0; i < N; i++) begin : g_az
		hatoaa_vec_cell #(.A(A), .IDX(i), .SW(VW + 1)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.v_in(av[i]), .rdy_out(ar[i]),
			.x_in(ax[i]), .y_in(ay[i]), .a_in(aa[i]), .side_in(as_[i]),
			.v_out(av[i+1]), .rdy_in(ar[i+1]),
			.x_out(ax[i+1]), .y_out(ay[i+1]), .a_out(aa[i+1]), .side_out(as_[i+1])
		);
	end

	// altitude chain
	assign bv[0] = v8_q;
	assign bx[0] = x_s8;
	assign by[0] = y_s8;
	assign ba[0] = ang_s8;
	assign bs[0] = side_s8;
	assign br[N] = rdy_o;

	for (genvar i = 0; i < N; i++) begin : g_alt
		hatoaa_vec_cell #(.A(A), .IDX(i), .SW(A + 1)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.v_in(bv[i]), .rdy_out(br[i]),
			.x_in(bx[i]), .y_in(by[i]), .a_in(ba[i]), .side_in(bs[i]),
			.v_out(bv[i+1]), .rdy_in(br[i+1]),
			.x_out(bx[i+1]), .y_out(by[i+1]), .a_out(ba[i+1]), .side_out(bs[i+1])
		);
	end

	// internal angle to port angle, round half up
	logic [A-1:0] az_a, alt_a;
	logic [A+32:0] az_w, alt_w;
	assign az_a = bs[N][A:1];
	assign alt_a = bs[N][0] ? A'(0) : ba[N];
	assign az_w = {1'b0, az_a, 32'd0} + ((A+33)'(1) << (A - 1));
	assign alt_w = {1'b0, alt_a, 32'd0} + ((A+33)'(1) << (A - 1));

	always_ff @(posedge clk) begin
		if (rdy_o && bv[N]) m_tdata <= {alt_w[A+31:A], az_w[A+31:A]};
	end

	// bx of the last altitude cell carries only the magnitude; by and ay carry the residual y
	logic unused_mag;
	assign unused_mag = ^{bx[N], by[N], ay[N]};

endmodule

`default_nettype wire
